[design/cbq_pkg.sv]
`timescale 1ns / 1ps
// cbq_pkg: shared widths, codes, microcode word and program rom for the
// cascaded biquad filter; no dependencies

package cbq_pkg;

  // field widths fixed by the interface
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 18;
  localparam int GAIN_W        = 16;
  localparam int COEF_IDX_W    = 6;
  localparam int NUM_STAGES_W  = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_STAGES_DEF = 8;
  localparam int TAPS          = 5;

  // datapath widths: one 18x16 product, five of them summed
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;

  // rounding shifts: Q6.31 sum down to Q1.15, Q5.27 gain product down to Q1.15
  localparam int STAGE_SHIFT = 16;
  localparam int GAIN_SHIFT  = 12;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32768));

  // reset values of the configuration registers
  localparam logic [NUM_STAGES_W-1:0] NUM_STAGES_RST = NUM_STAGES_W'(1);
  localparam logic [GAIN_W-1:0]       GAIN_RST       = GAIN_W'(4096);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STAGES = 1'b0,
    CFG_GAIN       = 1'b1
  } cfg_idx_t;

  // request opcodes
  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X,
    MUL_H1A,
    MUL_H2A,
    MUL_H1B,
    MUL_H2B,
    MUL_GAIN
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // branch conditions: when true jump to target, else fall through
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_WAIT_IN,
    BR_MORE_STAGES,
    BR_OUT_WAIT,
    BR_MORE_COLS
  } br_cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // program addresses
  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_STAGE    = 4'd1;
  localparam upc_t UPC_RD_B0    = 4'd1;
  localparam upc_t UPC_RD_B1    = 4'd2;
  localparam upc_t UPC_RD_B2    = 4'd3;
  localparam upc_t UPC_RD_A1    = 4'd4;
  localparam upc_t UPC_RD_A2    = 4'd5;
  localparam upc_t UPC_MAC_A2   = 4'd6;
  localparam upc_t UPC_ACC_A2   = 4'd7;
  localparam upc_t UPC_STG_END  = 4'd8;
  localparam upc_t UPC_GAIN_MUL = 4'd9;
  localparam upc_t UPC_GAIN_OUT = 4'd10;
  localparam upc_t UPC_FLUSH    = 4'd11;
  localparam upc_t UPC_DONE     = 4'd12;

  typedef struct packed {
    logic     rd_en;
    logic [2:0] pos;
    mul_sel_t mul;
    acc_op_t  acc;
    logic     stage_end;
    logic     gain_out;
    logic     flush;
    logic     done;
    br_cond_t cond;
    upc_t     target;
  } ucode_t;

  localparam ucode_t UCODE_NOP = '{
    rd_en: 1'b0, pos: 3'd0, mul: MUL_NONE, acc: ACC_NONE,
    stage_end: 1'b0, gain_out: 1'b0, flush: 1'b0, done: 1'b0,
    cond: BR_ALWAYS, target: UPC_IDLE
  };

  typedef struct packed {
    logic                       clip;
    logic signed [SAMPLE_W-1:0] value;
  } sat_res_t;

  // program rom: one biquad section is steps 1..8, then gain and history sweep
  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t uw;
    uw = UCODE_NOP;
    uw.cond = BR_NEXT;
    case (upc)
      UPC_IDLE: begin
        uw.cond   = BR_WAIT_IN;
        uw.target = UPC_IDLE;
      end
      UPC_RD_B0: begin
        uw.rd_en = 1'b1; uw.pos = 3'd0;
      end
      UPC_RD_B1: begin
        uw.rd_en = 1'b1; uw.pos = 3'd1; uw.mul = MUL_X;
      end
      UPC_RD_B2: begin
        uw.rd_en = 1'b1; uw.pos = 3'd2; uw.mul = MUL_H1A; uw.acc = ACC_LOAD;
      end
      UPC_RD_A1: begin
        uw.rd_en = 1'b1; uw.pos = 3'd3; uw.mul = MUL_H2A; uw.acc = ACC_ADD;
      end
      UPC_RD_A2: begin
        uw.rd_en = 1'b1; uw.pos = 3'd4; uw.mul = MUL_H1B; uw.acc = ACC_ADD;
      end
      UPC_MAC_A2: begin
        uw.mul = MUL_H2B; uw.acc = ACC_SUB;
      end
      UPC_ACC_A2: begin
        uw.acc = ACC_SUB;
      end
      UPC_STG_END: begin
        uw.stage_end = 1'b1;
        uw.cond      = BR_MORE_STAGES;
        uw.target    = UPC_STAGE;
      end
      UPC_GAIN_MUL: begin
        uw.mul = MUL_GAIN;
      end
      UPC_GAIN_OUT: begin
        uw.gain_out = 1'b1;
        uw.cond     = BR_OUT_WAIT;
        uw.target   = UPC_GAIN_OUT;
      end
      UPC_FLUSH: begin
        uw.flush  = 1'b1;
        uw.cond   = BR_MORE_COLS;
        uw.target = UPC_FLUSH;
      end
      UPC_DONE: begin
        uw.done   = 1'b1;
        uw.cond   = BR_ALWAYS;
        uw.target = UPC_IDLE;
      end
      default: begin
        uw = UCODE_NOP;
      end
    endcase
    return uw;
  endfunction

  // round half up by 2^sh, then clip to 16 bits
  function automatic sat_res_t round_sat(input logic signed [ACC_W-1:0] v, input int sh);
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] r;
    sat_res_t res;
    half = '0;
    half[sh-1] = 1'b1;
    r = (v + half) >>> sh;
    if (r > SAT_HI) begin
      res.clip  = 1'b1;
      res.value = 16'sh7fff;
    end else if (r < SAT_LO) begin
      res.clip  = 1'b1;
      res.value = 16'sh8000;
    end else begin
      res.clip  = 1'b0;
      res.value = r[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

[design/cbq_ram.sv]
`timescale 1ns / 1ps
// cbq_ram: generic single write port ram with one registered read port
// depends on cbq_pkg for default sizes

module cbq_ram import cbq_pkg::*; #(
  parameter int WIDTH = COEF_W,
  parameter int DEPTH = TAPS * MAX_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/cascaded_biquad_iir_filter.sv]
`timescale 1ns / 1ps
// cascaded_biquad_iir_filter: direct form I biquad cascade run by a microcoded
// sequencer over one shared multiplier; depends on cbq_pkg and cbq_ram
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | op, sample, last_in_block, coef_index, coef_value
//  out     | out_valid/out_stall| filtered_sample, block_end, saturated
//  cfg     | cfg_write_en       | cfg_index, cfg_data
//
// a sample request runs eight program steps per active section on the one
// multiplier, then gain, then a sweep that rotates the history until every
// column has turned once; a coefficient request is written as it is taken.
// a finished result waits in the output register while the next request runs;
// the sequencer only holds at the gain step if that register is still full.
// synchronous reset restores the register defaults, clears history and marks
// every coefficient entry as zero.

module cascaded_biquad_iir_filter import cbq_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [SAMPLE_W-1:0]    sample,
  input  logic                          last_in_block,
  input  logic [COEF_IDX_W-1:0]         coef_index,
  input  logic signed [COEF_W-1:0]      coef_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_W-1:0]    filtered_sample,
  output logic                          block_end,
  output logic                          saturated,
  input  logic                          cfg_write_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int NCOEF = TAPS * MAX_STAGES;
  localparam int NCOL  = MAX_STAGES + 1;
  localparam int CA_W  = $clog2(NCOEF);
  localparam int COL_W = $clog2(NCOL + 1);

  // configuration
  logic [NUM_STAGES_W-1:0]   num_stages;
  logic signed [GAIN_W-1:0]  gain;

  // sequencer
  upc_t   upc, upc_next;
  ucode_t uw;

  // datapath
  logic [COL_W-1:0]           col, col_inc, n_eff;
  logic [CA_W-1:0]            coef_base, coef_raddr;
  logic [COEF_W-1:0]          coef_rdata;
  logic                       coef_valid [NCOEF];
  logic                       coef_ok;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext, acc;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [SAMPLE_W-1:0] h1 [NCOL];
  logic signed [SAMPLE_W-1:0] h2 [NCOL];
  logic                       last_q, sat_q;
  sat_res_t                   stage_y, gain_y;

  logic in_acc, sample_go, coef_go, out_block;

  // request handshake
  assign in_stall  = (upc != UPC_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign sample_go = in_acc && (op == OP_FILTER);
  assign coef_go   = in_acc && (op == OP_COEF) && (int'(coef_index) < NCOEF);
  assign out_block = out_valid && out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= NUM_STAGES_RST;
      gain       <= GAIN_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_NUM_STAGES: num_stages <= cfg_data[NUM_STAGES_W-1:0];
        CFG_GAIN:       gain       <= cfg_data[GAIN_W-1:0];
        default:        ;
      endcase
    end
  end

  // effective section count, clamped to 1..MAX_STAGES
  always_comb begin
    if (num_stages == '0) begin
      n_eff = COL_W'(1);
    end else if (int'(num_stages) > MAX_STAGES) begin
      n_eff = COL_W'(MAX_STAGES);
    end else begin
      n_eff = COL_W'(num_stages);
    end
  end

  // control word fetch
  assign uw      = ucode_rom(upc);
  assign col_inc = col + COL_W'(1);

  // next program step
  always_comb begin
    case (uw.cond)
      BR_NEXT:        upc_next = upc + upc_t'(1);
      BR_ALWAYS:      upc_next = uw.target;
      BR_WAIT_IN:     upc_next = sample_go ? upc + upc_t'(1) : uw.target;
      BR_MORE_STAGES: upc_next = (col_inc != n_eff) ? uw.target : upc + upc_t'(1);
      BR_OUT_WAIT:    upc_next = out_block ? uw.target : upc + upc_t'(1);
      BR_MORE_COLS:   upc_next = (col_inc != COL_W'(NCOL)) ? uw.target : upc + upc_t'(1);
      default:        upc_next = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // coefficient store
  assign coef_raddr = coef_base + CA_W'(uw.pos);

  cbq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (NCOEF)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_go),
    .waddr (CA_W'(coef_index)),
    .wdata (coef_value),
    .re    (uw.rd_en),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // written marks: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_valid[i] <= 1'b0;
      end
      coef_ok <= 1'b0;
    end else begin
      if (coef_go) begin
        coef_valid[CA_W'(coef_index)] <= 1'b1;
      end
      if (uw.rd_en) begin
        coef_ok <= coef_valid[coef_raddr];
      end
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = coef_ok ? coef_rdata : '0;
    case (uw.mul)
      MUL_X:    mul_b = x_cur;
      MUL_H1A:  mul_b = h1[0];
      MUL_H2A:  mul_b = h2[0];
      MUL_H1B:  mul_b = h1[1];
      MUL_H2B:  mul_b = h2[1];
      MUL_GAIN: begin
        mul_a = {{(COEF_W-GAIN_W){gain[GAIN_W-1]}}, gain};
        mul_b = x_cur;
      end
      default:  mul_b = '0;
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign stage_y  = round_sat(acc, STAGE_SHIFT);
  assign gain_y   = round_sat(prod_ext, GAIN_SHIFT);

  // product register and accumulator
  always_ff @(posedge clk) begin
    if (uw.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (uw.acc)
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      ACC_SUB:  acc <= acc - prod_ext;
      default:  ;
    endcase
  end

  // section counters, current value and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      coef_base <= '0;
      sat_q     <= 1'b0;
    end else if (sample_go) begin
      col       <= '0;
      coef_base <= '0;
      sat_q     <= 1'b0;
    end else if (uw.stage_end) begin
      col       <= col_inc;
      coef_base <= coef_base + CA_W'(TAPS);
      sat_q     <= sat_q | stage_y.clip;
    end else if (uw.flush) begin
      col       <= col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_go) begin
      x_cur  <= sample;
      last_q <= last_in_block;
    end else if (uw.stage_end) begin
      x_cur  <= stage_y.value;
    end else if (uw.flush) begin
      x_cur  <= '0;
    end
  end

  // history: column under work sits at index 0, rotated once per section and sweep step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOL; i++) begin
        h1[i] <= '0;
        h2[i] <= '0;
      end
    end else if (uw.done && last_q) begin
      for (int i = 0; i < NCOL; i++) begin
        h1[i] <= '0;
        h2[i] <= '0;
      end
    end else if (uw.stage_end || uw.flush) begin
      for (int i = 0; i < NCOL - 1; i++) begin
        h1[i] <= h1[i+1];
        h2[i] <= h2[i+1];
      end
      h1[NCOL-1] <= x_cur;
      h2[NCOL-1] <= h1[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.gain_out && !out_block) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.gain_out && !out_block) begin
      filtered_sample <= gain_y.value;
      block_end       <= last_q;
      saturated       <= sat_q | gain_y.clip;
    end
  end

  // a new result only appears from the gain step
  a_out_from_gain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(upc) == UPC_GAIN_OUT)
    else $error("result raised outside the gain step");

  // every history column has been rotated exactly once when a request ends
  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    upc == UPC_DONE |-> col == COL_W'(NCOL))
    else $error("history sweep incomplete at end of request");

  // last sample of a block leaves history cleared
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_DONE && last_q) |=> (h1[0] == '0 && h2[0] == '0 && h1[1] == '0))
    else $error("history not cleared after block end");

  // an accepted sample starts at the first section with the section count cleared
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    sample_go |=> upc == UPC_STAGE && col == '0)
    else $error("sample started with stale section count");

endmodule

[tb/cbq_checker.sv]
`timescale 1ns / 1ps
// cbq_checker: watches the request, result and register ports of the biquad cascade,
// predicts every filtered sample and compares it field by field; depends on cbq_pkg

module cbq_checker import cbq_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       op,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_in_block,
  input  logic [COEF_IDX_W-1:0]      coef_index,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] filtered_sample,
  input  logic                       block_end,
  input  logic                       saturated,
  input  logic                       cfg_write_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         pending
);

  localparam int NCOEF = TAPS * MAX_STAGES;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       block_end;
    logic                       clip;
  } filt_result_t;

  // model state: coefficient store, two history rows, registers
  logic signed [COEF_W-1:0]   coef_mem [NCOEF];
  logic signed [SAMPLE_W-1:0] hist_z1 [MAX_STAGES+1];
  logic signed [SAMPLE_W-1:0] hist_z2 [MAX_STAGES+1];
  logic [NUM_STAGES_W-1:0]    stage_cfg;
  logic signed [GAIN_W-1:0]   gain_cfg;
  logic                       clip_seen;
  filt_result_t               expected_outputs [$];

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    fail_count++;
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic void clear_history();
    foreach (hist_z1[i]) begin
      hist_z1[i] = '0;
      hist_z2[i] = '0;
    end
  endfunction

  // round half up by 2^sh, then clip to 16 bits; clipping is remembered
  function automatic logic signed [SAMPLE_W-1:0] shift_clip(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 32767) begin
      clip_seen = 1'b1;
      return 16'sh7fff;
    end
    if (r < -32768) begin
      clip_seen = 1'b1;
      return 16'sh8000;
    end
    return SAMPLE_W'(r);
  endfunction

  // run one sample through the active sections and the gain, then advance history
  function automatic filt_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic end_of_block);
    logic signed [SAMPLE_W-1:0] cur [MAX_STAGES+1];
    longint acc;
    int n;
    filt_result_t res;
    clip_seen = 1'b0;
    n = int'(stage_cfg);
    if (n < 1) n = 1;
    if (n > MAX_STAGES) n = MAX_STAGES;
    foreach (cur[i]) cur[i] = '0;
    cur[0] = x;
    for (int s = 0; s < n; s++) begin
      acc = longint'(coef_mem[TAPS*s])   * cur[s]
          + longint'(coef_mem[TAPS*s+1]) * hist_z1[s]
          + longint'(coef_mem[TAPS*s+2]) * hist_z2[s]
          - longint'(coef_mem[TAPS*s+3]) * hist_z1[s+1]
          - longint'(coef_mem[TAPS*s+4]) * hist_z2[s+1];
      cur[s+1] = shift_clip(acc, STAGE_SHIFT);
    end
    res.value = shift_clip(longint'(gain_cfg) * cur[n], GAIN_SHIFT);
    res.block_end = end_of_block;
    res.clip = clip_seen;
    // inactive columns of cur are zero, so they stay zero in history
    if (end_of_block) begin
      clear_history();
    end else begin
      hist_z2 = hist_z1;
      hist_z1 = cur;
    end
    return res;
  endfunction

  // everything is sampled at the rising edge; results are checked before new requests
  always @(posedge clk) begin : watch
    filt_result_t want;
    if (rst) begin
      foreach (coef_mem[i]) coef_mem[i] = '0;
      clear_history();
      stage_cfg = NUM_STAGES_RST;
      gain_cfg  = GAIN_RST;
      expected_outputs.delete();
    end else begin
      // result side
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch("result with none outstanding", 0, filtered_sample);
        end else begin
          want = expected_outputs.pop_front();
          if (filtered_sample !== want.value)
            report_mismatch("filtered_sample", want.value, filtered_sample);
          if (block_end !== want.block_end)
            report_mismatch("block_end", want.block_end, block_end);
          if (saturated !== want.clip)
            report_mismatch("saturated", want.clip, saturated);
        end
      end
      // register writes
      if (cfg_write_en === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_STAGES: stage_cfg = cfg_data[NUM_STAGES_W-1:0];
          CFG_GAIN:       gain_cfg  = cfg_data;
          default: ;
        endcase
      end
      // request side
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (op == OP_COEF) begin
          if (coef_index < NCOEF) coef_mem[coef_index] = coef_value;
        end else begin
          expected_outputs.push_back(filter_sample(sample, last_in_block));
        end
      end
    end
    pending = expected_outputs.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: clock, reset, request and register stimulus and result stalls for
// cascaded_biquad_iir_filter, plus the verdict; depends on cbq_pkg, cbq_checker and the filter

module tb_top import cbq_pkg::*; ();

  localparam int MAX_STAGES    = MAX_STAGES_DEF;
  localparam int SETTLE_CYCLES = 100;  // enough for one sample request through every section
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 500;
  localparam int REQ_W         = 1 + SAMPLE_W + 1 + COEF_IDX_W + COEF_W;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_block;
  logic [COEF_IDX_W-1:0]      coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       block_end;
  logic                       saturated;
  logic                       cfg_write_en;
  cfg_idx_t                   cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int   fail_count;
  int   pending;
  int   items_sent = 0;
  logic calm = 1'b0;         // no idling on either side
  logic rx_hold_req = 1'b0;  // ask the result side for one long stall

  cascaded_biquad_iir_filter #(.MAX_STAGES(MAX_STAGES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sample(sample), .last_in_block(last_in_block),
    .coef_index(coef_index), .coef_value(coef_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_sample(filtered_sample), .block_end(block_end), .saturated(saturated),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbq_checker #(.MAX_STAGES(MAX_STAGES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sample(sample), .last_in_block(last_in_block),
    .coef_index(coef_index), .coef_value(coef_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_sample(filtered_sample), .block_end(block_end), .saturated(saturated),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall before each result, one long hold on request
  initial begin : result_sink
    int hold;
    logic long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (rx_hold_req && !long_done) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_done = 1'b1;
      end
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one request after a random gap; returns at the falling edge after acceptance
  task automatic send_req(input op_t o, input logic signed [SAMPLE_W-1:0] s,
                          input logic lib, input logic [COEF_IDX_W-1:0] ci,
                          input logic signed [COEF_W-1:0] cv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      {op, sample, last_in_block, coef_index, coef_value} = REQ_W'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    op            = o;
    sample        = s;
    last_in_block = lib;
    coef_index    = ci;
    coef_value    = cv;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result, then for the block to go idle
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = data;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef(input int pos, input logic wild);
    if (wild) return COEF_W'($urandom);
    // small enough that the sections stay stable most of the time
    case (pos)
      3:       return COEF_W'($urandom_range(0, 65536) - 32768);
      4:       return COEF_W'($urandom_range(0, 32768) - 16384);
      default: return COEF_W'($urandom_range(0, 65536) - 32768);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       return SAMPLE_W'($urandom_range(0, 512) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one random phase: registers, full coefficient set for the active sections,
  // then a stream of samples with occasional retunes and stray coefficient writes
  task automatic random_phase(input int p);
    logic [NUM_STAGES_W-1:0] code;
    logic [GAIN_W-1:0] g;
    logic wild;
    int n;
    wait_quiet();
    case (p % 6)
      0:       code = 4'd1;
      1:       code = 4'd8;
      2:       code = 4'd0;
      3:       code = 4'd15;
      4:       code = 4'd2;
      default: code = NUM_STAGES_W'($urandom_range(3, 7));
    endcase
    case (p % 5)
      0:       g = 16'd4096;
      1:       g = 16'h7fff;
      2:       g = 16'h8000;
      3:       g = GAIN_W'($urandom);
      default: g = GAIN_W'($urandom_range(2048, 8192));
    endcase
    write_reg(CFG_NUM_STAGES, {12'($urandom), code});
    write_reg(CFG_GAIN, g);
    n = (code == 0) ? 1 : (code > MAX_STAGES) ? MAX_STAGES : int'(code);
    wild = ($urandom_range(0, 3) == 0);
    calm = (p == 3);
    for (int i = 0; i < TAPS * n; i++)
      send_req(OP_COEF, SAMPLE_W'($urandom), 1'($urandom), COEF_IDX_W'(i),
               pick_coef(i % TAPS, wild));
    if (p == 1) rx_hold_req = 1'b1;
    repeat (60) begin
      case ($urandom_range(0, 19))
        0: send_req(OP_COEF, SAMPLE_W'($urandom), 1'($urandom), COEF_IDX_W'($urandom),
                    COEF_W'($urandom));
        1: send_req(OP_COEF, SAMPLE_W'($urandom), 1'($urandom),
                    COEF_IDX_W'($urandom_range(0, TAPS * n - 1)),
                    pick_coef($urandom_range(0, TAPS - 1), wild));
        default: send_req(OP_FILTER, pick_sample(), ($urandom_range(0, 15) == 0),
                          COEF_IDX_W'($urandom), COEF_W'($urandom));
      endcase
    end
    calm = 1'b0;
  endtask

  // main sequence
  initial begin : stimulus
    int first_random;
    int p;
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_FILTER;
    sample        = '0;
    last_in_block = 1'b0;
    coef_index    = '0;
    coef_value    = '0;
    cfg_write_en  = 1'b0;
    cfg_index     = CFG_NUM_STAGES;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: pass-through section at reset settings, ignored writes, extremes
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd0, 18'sh10000);
    send_req(OP_COEF, 16'sh7fff, 1'b1, 6'd63, 18'sh20000);
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd40, 18'sh1ffff);
    send_req(OP_FILTER, 16'sh7fff, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sh8000, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sh0000, 1'b1, 6'd0, 18'sh0);
    // strong feedback so the section itself clips
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd3, 18'sh20000);
    send_req(OP_FILTER, 16'sd20000, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sd20000, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sd1, 1'b1, 6'd0, 18'sh0);
    // coefficient write with last_in_block set, extremes at the store edges
    send_req(OP_COEF, 16'sh0000, 1'b1, 6'd3, 18'sh00000);
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd4, 18'sh1ffff);
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd39, 18'sh1ffff);
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd1, 18'sh1ffff);
    send_req(OP_COEF, 16'sh0000, 1'b0, 6'd2, 18'sh20000);
    send_req(OP_FILTER, 16'sh8000, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sh7fff, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'shffff, 1'b1, 6'd0, 18'sh0);
    // stage count zero with the most negative gain
    wait_quiet();
    write_reg(CFG_NUM_STAGES, 16'h0000);
    write_reg(CFG_GAIN, 16'h8000);
    send_req(OP_FILTER, 16'sh7fff, 1'b1, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sh0001, 1'b1, 6'd0, 18'sh0);
    // stage count above the maximum with the largest gain
    wait_quiet();
    write_reg(CFG_NUM_STAGES, 16'hfffb);
    write_reg(CFG_GAIN, 16'h7fff);
    send_req(OP_FILTER, 16'sd12345, 1'b0, 6'd0, 18'sh0);
    send_req(OP_FILTER, 16'sh8000, 1'b1, 6'd0, 18'sh0);

    // random phases
    first_random = items_sent;
    p = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      random_phase(p);
      p++;
    end

    wait_quiet();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
design/cbq_pkg.sv
design/cbq_ram.sv
design/cascaded_biquad_iir_filter.sv
tb/cbq_checker.sv
tb/tb_top.sv
